FILE: hw/rtl/cbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cbc_pkg;

    localparam int FRAME_WIDTH_DEF  = 512;
    localparam int FRAME_HEIGHT_DEF = 256;
    localparam int COORD_CMP_W      = 13;

    localparam int TALLY_W  = 18;
    localparam int COLSUM_W = 27;
    localparam int ROWSUM_W = 26;
    localparam int XC_W     = 9;
    localparam int YC_W     = 8;
    localparam int CFG_W    = 18;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BALL_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HUE_CENTER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HUE_BIAS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT  = 2'd3;

    localparam logic [15:0] MASK_RED  = 16'hf800;
    localparam logic [15:0] MASK_BLUE = 16'h001f;

    localparam logic signed [10:0] HUE_FULL = 11'sd360;

    localparam logic [7:0] SAT_MIN = 8'd144;
    localparam logic [7:0] VAL_MIN = 8'd102;

    localparam logic [7:0] BLUE_R_LO = 8'd50;
    localparam logic [7:0] BLUE_R_HI = 8'd90;
    localparam logic [7:0] BLUE_G_LO = 8'd95;
    localparam logic [7:0] BLUE_G_HI = 8'd130;
    localparam logic [7:0] BLUE_B_LO = 8'd130;
    localparam logic [7:0] BLUE_B_HI = 8'd180;

    localparam logic [7:0] RED_R_LO = 8'd190;
    localparam logic [7:0] RED_R_HI = 8'd225;
    localparam logic [7:0] RED_G_LO = 8'd100;
    localparam logic [7:0] RED_G_HI = 8'd150;
    localparam logic [7:0] RED_B_LO = 8'd60;
    localparam logic [7:0] RED_B_HI = 8'd120;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y
    } state_t;

    typedef struct packed {
        logic       ball_color;
        logic [8:0] hue_center;
        logic [7:0] hue_bias;
    } cls_cfg_t;

    typedef struct packed {
        logic        match;
        logic [15:0] mask;
    } cls_result_t;

    // c * 255 / 31 = 8c + 7c / 31; 7c / 31 by reciprocal 2115 / 2^16
    function automatic logic [7:0] expand5(input logic [4:0] c);
        logic [7:0]  w;
        logic [19:0] prod;
        begin
            w    = 8'(c) * 8'd7;
            prod = 20'(w) * 20'd2115;
            expand5 = {c, 3'b000} + {5'b0, prod[18:16]};
        end
    endfunction

    // g * 255 / 63 = 4g + g / 21
    function automatic logic [7:0] expand6(input logic [5:0] g);
        logic [1:0] q;
        begin
            q = 2'((g >= 6'd21) ? 1 : 0) + 2'((g >= 6'd42) ? 1 : 0)
              + 2'((g >= 6'd63) ? 1 : 0);
            expand6 = {g, 2'b00} + {6'b0, q};
        end
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/cbc_classify.sv
`timescale 1ns / 1ps
`default_nettype none
module cbc_classify
(
    input  wire cbc_pkg::cls_cfg_t    cfg,
    input  wire logic [15:0]          pixel_rgb565,
    input  wire logic [8:0]           hue,
    input  wire logic [7:0]           saturation,
    input  wire logic [7:0]           brightness,
    output cbc_pkg::cls_result_t      result
);

    logic [7:0]        r;
    logic [7:0]        g;
    logic [7:0]        b;
    logic signed [10:0] lo0, hi0, lo1, hi1, lo2, hi2, hue_s;
    logic              rest_common;
    logic              in_window;
    logic              out_window;
    logic              blue_rgb;
    logic              red_rgb;

    assign r = cbc_pkg::expand5(pixel_rgb565[15:11]);
    assign g = cbc_pkg::expand6(pixel_rgb565[10:5]);
    assign b = cbc_pkg::expand5(pixel_rgb565[4:0]);

    always_comb
    begin
        lo0 = $signed({2'b00, cfg.hue_center}) - $signed({3'b000, cfg.hue_bias});
        hi0 = $signed({2'b00, cfg.hue_center}) + $signed({3'b000, cfg.hue_bias});
        if (lo0 < 0)
        begin
            lo1 = hi0;
            hi1 = lo0 + cbc_pkg::HUE_FULL;
        end
        else
        begin
            lo1 = lo0;
            hi1 = hi0;
        end
        if (hi1 >= cbc_pkg::HUE_FULL)
        begin
            lo2 = hi1 - cbc_pkg::HUE_FULL;
            hi2 = lo1;
        end
        else
        begin
            lo2 = lo1;
            hi2 = hi1;
        end
    end

    assign hue_s       = $signed({2'b00, hue});
    assign in_window   = (hue_s > lo2) && (hue_s < hi2);
    assign out_window  = (hue_s < lo2) || (hue_s > hi2);
    assign rest_common = (saturation > cbc_pkg::SAT_MIN) && (brightness > cbc_pkg::VAL_MIN);

    assign blue_rgb = (r > cbc_pkg::BLUE_R_LO) && (r < cbc_pkg::BLUE_R_HI)
                   && (g > cbc_pkg::BLUE_G_LO) && (g < cbc_pkg::BLUE_G_HI)
                   && (b > cbc_pkg::BLUE_B_LO) && (b < cbc_pkg::BLUE_B_HI);
    assign red_rgb  = (r > cbc_pkg::RED_R_LO) && (r < cbc_pkg::RED_R_HI)
                   && (g > cbc_pkg::RED_G_LO) && (g < cbc_pkg::RED_G_HI)
                   && (b > cbc_pkg::RED_B_LO) && (b < cbc_pkg::RED_B_HI);

    always_comb
    begin
        if (cfg.ball_color)
        begin
            result.match = in_window && rest_common && blue_rgb;
            result.mask  = cbc_pkg::MASK_BLUE;
        end
        else
        begin
            result.match = out_window && rest_common && red_rgb;
            result.mask  = cbc_pkg::MASK_RED;
        end
        if (!result.match)
        begin
            result.mask = 16'h0000;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/cbc_divider.sv
`timescale 1ns / 1ps
`default_nettype none
module cbc_divider
#(
    parameter int DVD_W = cbc_pkg::COLSUM_W,
    parameter int DVS_W = cbc_pkg::TALLY_W
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic [DVD_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] dq_reg, dq_next;
    logic [DVS_W:0]   rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   rem_sh;
    logic             fits;

    assign rem_sh = {rem_reg[DVS_W-1:0], dq_reg[DVD_W-1]};
    assign fits   = rem_sh >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W);
            dq_next   = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
            dq_next  = {dq_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/color_blob_centroid.sv
`timescale 1ns / 1ps
`default_nettype none
// Color blob centroid: classifies each RGB565 pixel (with its looked-up hue,
// saturation and value) as a red or blue target match against a hue window
// and fixed color ranges, returns a mask pixel for every pixel, and keeps the
// match count and clamped coordinate sums. A pixel without last_pixel updates
// the sums and gives its mask pixel. On the last pixel the count is reported
// and, when it exceeds min_count, the mean column and row come from one
// shared restoring divider that makes one quotient bit per cycle, column
// first, with in_ready low meanwhile. Accumulators clear after the last
// pixel. Write the configuration registers only while the block is idle.
module color_blob_centroid
#(
    parameter int FRAME_WIDTH  = cbc_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = cbc_pkg::FRAME_HEIGHT_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [cbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cbc_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [15:0]                   pixel_rgb565,
    input  wire logic [8:0]                    hue,
    input  wire logic [7:0]                    saturation,
    input  wire logic [7:0]                    brightness,
    input  wire logic [8:0]                    x_coord,
    input  wire logic [7:0]                    y_coord,
    input  wire logic                          last_pixel,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [15:0]                        mask_pixel,
    output logic                               ball_found,
    output logic [cbc_pkg::TALLY_W-1:0]        match_count,
    output logic [cbc_pkg::XC_W-1:0]           x_center,
    output logic [cbc_pkg::YC_W-1:0]           y_center
);

    localparam int TW = cbc_pkg::TALLY_W;
    localparam int CW = cbc_pkg::COLSUM_W;
    localparam int RW = cbc_pkg::ROWSUM_W;
    localparam int KW = cbc_pkg::COORD_CMP_W;
    localparam logic [KW-1:0] X_LIMIT = KW'(FRAME_WIDTH);
    localparam logic [KW-1:0] Y_LIMIT = KW'(FRAME_HEIGHT);

    cbc_pkg::cls_cfg_t    cls_cfg;
    cbc_pkg::cls_result_t cls;
    cbc_pkg::state_t      state_reg, state_next;

    logic [17:0]   min_count_reg;
    logic          ball_color_reg;
    logic [8:0]    hue_center_reg;
    logic [7:0]    hue_bias_reg;

    logic [TW-1:0] tally_reg, tally_next;
    logic [CW-1:0] colsum_reg, colsum_next;
    logic [RW-1:0] rowsum_reg, rowsum_next;
    logic [TW-1:0] div_tally_reg, div_tally_next;
    logic [RW-1:0] div_row_reg, div_row_next;
    logic [15:0]   pend_mask_reg, pend_mask_next;
    logic [8:0]    qx_reg, qx_next;

    logic          out_valid_reg, out_valid_next;
    logic [15:0]   mask_reg, mask_next;
    logic          found_reg, found_next;
    logic [TW-1:0] count_reg, count_next;
    logic [8:0]    xc_reg, xc_next;
    logic [7:0]    yc_reg, yc_next;

    logic          accept;
    logic [8:0]    cx;
    logic [7:0]    cy;
    logic [TW:0]   tally_inc;
    logic [CW:0]   colsum_inc;
    logic [RW:0]   rowsum_inc;
    logic [TW-1:0] tally_upd;
    logic [CW-1:0] colsum_upd;
    logic [RW-1:0] rowsum_upd;
    logic          found_now;

    logic          div_start;
    logic [CW-1:0] div_dividend;
    logic [TW-1:0] div_divisor;
    logic          div_done;
    logic [CW-1:0] div_quot;

    assign cls_cfg.ball_color = ball_color_reg;
    assign cls_cfg.hue_center = hue_center_reg;
    assign cls_cfg.hue_bias   = hue_bias_reg;

    cbc_classify u_classify
    (
        .cfg          (cls_cfg),
        .pixel_rgb565 (pixel_rgb565),
        .hue          (hue),
        .saturation   (saturation),
        .brightness   (brightness),
        .result       (cls)
    );

    cbc_divider
    #(
        .DVD_W (CW),
        .DVS_W (TW)
    )
    u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ball_color_reg <= 1'b0;
            hue_center_reg <= '0;
            hue_bias_reg   <= '0;
            min_count_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cbc_pkg::CFG_BALL_COLOR: ball_color_reg <= cfg_data[0];
                cbc_pkg::CFG_HUE_CENTER: hue_center_reg <= cfg_data[8:0];
                cbc_pkg::CFG_HUE_BIAS:   hue_bias_reg   <= cfg_data[7:0];
                cbc_pkg::CFG_MIN_COUNT:  min_count_reg  <= cfg_data[17:0];
                default:                 min_count_reg  <= min_count_reg;
            endcase
        end
    end

    assign in_ready = (state_reg == cbc_pkg::ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    assign cx = ({{(KW-9){1'b0}}, x_coord} >= X_LIMIT) ? 9'(FRAME_WIDTH - 1) : x_coord;
    assign cy = ({{(KW-8){1'b0}}, y_coord} >= Y_LIMIT) ? 8'(FRAME_HEIGHT - 1) : y_coord;

    assign tally_inc  = {1'b0, tally_reg} + (TW+1)'(1);
    assign colsum_inc = {1'b0, colsum_reg} + (CW+1)'(cx);
    assign rowsum_inc = {1'b0, rowsum_reg} + (RW+1)'(cy);

    always_comb
    begin
        tally_upd  = tally_reg;
        colsum_upd = colsum_reg;
        rowsum_upd = rowsum_reg;
        if (cls.match)
        begin
            tally_upd  = tally_inc[TW]  ? {TW{1'b1}} : tally_inc[TW-1:0];
            colsum_upd = colsum_inc[CW] ? {CW{1'b1}} : colsum_inc[CW-1:0];
            rowsum_upd = rowsum_inc[RW] ? {RW{1'b1}} : rowsum_inc[RW-1:0];
        end
    end

    assign found_now = tally_upd > min_count_reg;

    assign div_start    = (accept && last_pixel && found_now)
                       || ((state_reg == cbc_pkg::ST_DIV_X) && div_done);
    assign div_dividend = (state_reg == cbc_pkg::ST_IDLE) ? colsum_upd
                                                          : CW'(div_row_reg);
    assign div_divisor  = (state_reg == cbc_pkg::ST_IDLE) ? tally_upd : div_tally_reg;

    always_comb
    begin
        state_next     = state_reg;
        tally_next     = tally_reg;
        colsum_next    = colsum_reg;
        rowsum_next    = rowsum_reg;
        div_tally_next = div_tally_reg;
        div_row_next   = div_row_reg;
        pend_mask_next = pend_mask_reg;
        qx_next        = qx_reg;
        out_valid_next = out_valid_reg;
        mask_next      = mask_reg;
        found_next     = found_reg;
        count_next     = count_reg;
        xc_next        = xc_reg;
        yc_next        = yc_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            cbc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (!last_pixel)
                    begin
                        tally_next     = tally_upd;
                        colsum_next    = colsum_upd;
                        rowsum_next    = rowsum_upd;
                        out_valid_next = 1'b1;
                        mask_next      = cls.mask;
                        found_next     = 1'b0;
                        count_next     = '0;
                        xc_next        = '0;
                        yc_next        = '0;
                    end
                    else
                    begin
                        tally_next  = '0;
                        colsum_next = '0;
                        rowsum_next = '0;
                        if (found_now)
                        begin
                            div_tally_next = tally_upd;
                            div_row_next   = rowsum_upd;
                            pend_mask_next = cls.mask;
                            state_next     = cbc_pkg::ST_DIV_X;
                        end
                        else
                        begin
                            out_valid_next = 1'b1;
                            mask_next      = cls.mask;
                            found_next     = 1'b0;
                            count_next     = tally_upd;
                            xc_next        = '0;
                            yc_next        = '0;
                        end
                    end
                end
            end
            cbc_pkg::ST_DIV_X:
            begin
                if (div_done)
                begin
                    qx_next    = (|div_quot[CW-1:9]) ? 9'h1ff : div_quot[8:0];
                    state_next = cbc_pkg::ST_DIV_Y;
                end
            end
            cbc_pkg::ST_DIV_Y:
            begin
                if (div_done)
                begin
                    out_valid_next = 1'b1;
                    mask_next      = pend_mask_reg;
                    found_next     = 1'b1;
                    count_next     = div_tally_reg;
                    xc_next        = qx_reg;
                    yc_next        = (|div_quot[CW-1:8]) ? 8'hff : div_quot[7:0];
                    state_next     = cbc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cbc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cbc_pkg::ST_IDLE;
            tally_reg     <= '0;
            colsum_reg    <= '0;
            rowsum_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tally_reg     <= tally_next;
            colsum_reg    <= colsum_next;
            rowsum_reg    <= rowsum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_tally_reg <= div_tally_next;
        div_row_reg   <= div_row_next;
        pend_mask_reg <= pend_mask_next;
        qx_reg        <= qx_next;
        mask_reg      <= mask_next;
        found_reg     <= found_next;
        count_reg     <= count_next;
        xc_reg        <= xc_next;
        yc_reg        <= yc_next;
    end

    assign out_valid   = out_valid_reg;
    assign mask_pixel  = mask_reg;
    assign ball_found  = found_reg;
    assign match_count = count_reg;
    assign x_center    = xc_reg;
    assign y_center    = yc_reg;

endmodule
`default_nettype wire

FILE: dv/color_blob_centroid_tb.sv
`timescale 1ns / 1ps
module color_blob_centroid_tb;

    localparam int TALLY_W   = cbc_pkg::TALLY_W;
    localparam int XC_W      = cbc_pkg::XC_W;
    localparam int YC_W      = cbc_pkg::YC_W;
    localparam int CFG_W     = cbc_pkg::CFG_W;
    localparam int CFG_IDX_W = cbc_pkg::CFG_IDX_W;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 12;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int LONG_HOLD      = 150;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 74;
    localparam int MAX_REPORTS    = 10;

    localparam int FRAME_W   = 512;
    localparam int FRAME_H   = 256;
    localparam int HUE_WRAP  = 360;
    localparam int SAT_FLOOR = 144;
    localparam int VAL_FLOOR = 102;

    localparam int BLUE_R_MIN = 50;
    localparam int BLUE_R_MAX = 90;
    localparam int BLUE_G_MIN = 95;
    localparam int BLUE_G_MAX = 130;
    localparam int BLUE_B_MIN = 130;
    localparam int BLUE_B_MAX = 180;
    localparam int RED_R_MIN  = 190;
    localparam int RED_R_MAX  = 225;
    localparam int RED_G_MIN  = 100;
    localparam int RED_G_MAX  = 150;
    localparam int RED_B_MIN  = 60;
    localparam int RED_B_MAX  = 120;

    localparam logic [15:0] RED_MASK  = 16'hf800;
    localparam logic [15:0] BLUE_MASK = 16'h001f;

    localparam longint TALLY_TOP  = 64'h3FFFF;
    localparam longint COLSUM_TOP = 64'h7FFFFFF;
    localparam longint ROWSUM_TOP = 64'h3FFFFFF;
    localparam longint XC_TOP     = 64'h1FF;
    localparam longint YC_TOP     = 64'hFF;

    typedef struct packed {
        logic [15:0] rgb;
        logic [8:0]  hue;
        logic [7:0]  sat;
        logic [7:0]  val;
        logic [8:0]  x;
        logic [7:0]  y;
        logic        last;
    } pixel_t;

    typedef struct packed {
        logic [15:0]        mask;
        logic               found;
        logic [TALLY_W-1:0] count;
        logic [XC_W-1:0]    xc;
        logic [YC_W-1:0]    yc;
    } blob_result_t;

    typedef struct packed {
        logic             blue;
        logic [8:0]       center;
        logic [7:0]       half;
        logic [CFG_W-1:0] min_hits;
    } blob_setting_t;

    class blob_scoreboard;
        logic             want_blue;
        logic [8:0]       win_center;
        logic [7:0]       win_half;
        logic [CFG_W-1:0] min_hits;
        longint           tally;
        longint           col_total;
        longint           row_total;
        blob_result_t     awaited[$];
        int               mismatches;
        int               checked;
        int               windows;
        int               blobs;
        int               red_hits;
        int               blue_hits;

        function new();
            want_blue  = 1'b0;
            win_center = '0;
            win_half   = '0;
            min_hits   = '0;
            tally      = 0;
            col_total  = 0;
            row_total  = 0;
            mismatches = 0;
            checked    = 0;
            windows    = 0;
            blobs      = 0;
            red_hits   = 0;
            blue_hits  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                cbc_pkg::CFG_BALL_COLOR: want_blue  = data[0];
                cbc_pkg::CFG_HUE_CENTER: win_center = data[8:0];
                cbc_pkg::CFG_HUE_BIAS:   win_half   = data[7:0];
                cbc_pkg::CFG_MIN_COUNT:  min_hits   = data;
                default: ;
            endcase
        endfunction

        function bit between(int v, int lo, int hi);
            return v > lo && v < hi;
        endfunction

        function void note_pixel(pixel_t p);
            blob_result_t e;
            int           r8;
            int           g8;
            int           b8;
            int           lo;
            int           hi;
            int           swap;
            int           h;
            bit           rest;
            bit           hit;
            longint       cx;
            longint       cy;
            longint       mx;
            longint       my;
            r8 = int'(p.rgb[15:11]) * 255 / 31;
            g8 = int'(p.rgb[10:5]) * 255 / 63;
            b8 = int'(p.rgb[4:0]) * 255 / 31;
            lo = int'(win_center) - int'(win_half);
            hi = int'(win_center) + int'(win_half);
            if (lo < 0)
            begin
                swap = hi;
                hi   = lo + HUE_WRAP;
                lo   = swap;
            end
            if (hi >= HUE_WRAP)
            begin
                swap = lo;
                lo   = hi - HUE_WRAP;
                hi   = swap;
            end
            h    = int'(p.hue);
            rest = int'(p.sat) > SAT_FLOOR && int'(p.val) > VAL_FLOOR;
            if (want_blue)
                hit = between(h, lo, hi) && rest && between(r8, BLUE_R_MIN, BLUE_R_MAX)
                    && between(g8, BLUE_G_MIN, BLUE_G_MAX)
                    && between(b8, BLUE_B_MIN, BLUE_B_MAX);
            else
                hit = (h < lo || h > hi) && rest && between(r8, RED_R_MIN, RED_R_MAX)
                    && between(g8, RED_G_MIN, RED_G_MAX)
                    && between(b8, RED_B_MIN, RED_B_MAX);
            e = '0;
            if (hit)
            begin
                e.mask = want_blue ? BLUE_MASK : RED_MASK;
                cx = (int'(p.x) >= FRAME_W) ? FRAME_W - 1 : longint'(p.x);
                cy = (int'(p.y) >= FRAME_H) ? FRAME_H - 1 : longint'(p.y);
                tally     = (tally + 1 > TALLY_TOP) ? TALLY_TOP : tally + 1;
                col_total = (col_total + cx > COLSUM_TOP) ? COLSUM_TOP : col_total + cx;
                row_total = (row_total + cy > ROWSUM_TOP) ? ROWSUM_TOP : row_total + cy;
                if (want_blue)
                    blue_hits++;
                else
                    red_hits++;
            end
            if (p.last)
            begin
                e.count = TALLY_W'(tally);
                if (tally > longint'(min_hits) && tally != 0)
                begin
                    mx      = col_total / tally;
                    my      = row_total / tally;
                    e.found = 1'b1;
                    e.xc    = XC_W'((mx > XC_TOP) ? XC_TOP : mx);
                    e.yc    = YC_W'((my > YC_TOP) ? YC_TOP : my);
                    blobs++;
                end
                windows++;
                tally     = 0;
                col_total = 0;
                row_total = 0;
            end
            awaited.push_back(e);
        endfunction

        function void check_result(blob_result_t got);
            blob_result_t e;
            checked++;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d with none due: mask=%h found=%b count=%0d x=%0d y=%0d",
                             checked, got.mask, got.found, got.count, got.xc, got.yc);
                return;
            end
            e = awaited.pop_front();
            if (got.mask !== e.mask || got.found !== e.found || got.count !== e.count
                || got.xc !== e.xc || got.yc !== e.yc)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("result %0d expected: mask=%h found=%b count=%0d x=%0d y=%0d",
                             checked, e.mask, e.found, e.count, e.xc, e.yc);
                    $display("result %0d actual:   mask=%h found=%b count=%0d x=%0d y=%0d",
                             checked, got.mask, got.found, got.count, got.xc, got.yc);
                end
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [15:0]          pixel_rgb565;
    logic [8:0]           hue;
    logic [7:0]           saturation;
    logic [7:0]           brightness;
    logic [8:0]           x_coord;
    logic [7:0]           y_coord;
    logic                 last_pixel;
    logic                 out_valid;
    logic                 out_ready;
    logic [15:0]          mask_pixel;
    logic                 ball_found;
    logic [TALLY_W-1:0]   match_count;
    logic [XC_W-1:0]      x_center;
    logic [YC_W-1:0]      y_center;

    blob_scoreboard sb;
    int             sent = 0;
    int             settings_used = 0;

    color_blob_centroid u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel_rgb565(pixel_rgb565),
        .hue         (hue),
        .saturation  (saturation),
        .brightness  (brightness),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .last_pixel  (last_pixel),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .mask_pixel  (mask_pixel),
        .ball_found  (ball_found),
        .match_count (match_count),
        .x_center    (x_center),
        .y_center    (y_center)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic pixel_t mk_pixel(int r5, int g6, int b5, int h, int s, int v,
                                        int x, int y, bit last);
        pixel_t p;
        p.rgb  = {5'(r5), 6'(g6), 5'(b5)};
        p.hue  = 9'(h);
        p.sat  = 8'(s);
        p.val  = 8'(v);
        p.x    = 9'(x);
        p.y    = 8'(y);
        p.last = last;
        return p;
    endfunction

    // near-miss ranges around each color box so both edges get hit
    function automatic pixel_t rand_pixel(bit blue, bit last, blob_setting_t s);
        pixel_t p;
        int     h;
        int     off;
        if ($urandom_range(0, 99) < 15)
        begin
            p      = 59'({$urandom, $urandom});
            p.last = last;
            return p;
        end
        if (blue)
        begin
            off = $urandom_range(0, 2 * int'(s.half) + 2) - (int'(s.half) + 1);
            h   = (int'(s.center) + off + 2 * HUE_WRAP) % HUE_WRAP;
            p   = mk_pixel($urandom_range(6, 11), $urandom_range(23, 33), $urandom_range(15, 22),
                           h, $urandom_range(140, 255), $urandom_range(98, 255),
                           $urandom_range(0, 511), $urandom_range(0, 255), last);
        end
        else
        begin
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(360, 511) : $urandom_range(0, 359);
            p = mk_pixel($urandom_range(23, 28), $urandom_range(24, 38), $urandom_range(7, 15),
                         h, $urandom_range(140, 255), $urandom_range(98, 255),
                         $urandom_range(0, 511), $urandom_range(0, 255), last);
        end
        return p;
    endfunction

    task automatic send_pixel(input pixel_t p);
        int gap;
        gap = (sent % 48 < 12) ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        pixel_rgb565 <= p.rgb;
        hue          <= p.hue;
        saturation   <= p.sat;
        brightness   <= p.val;
        x_coord      <= p.x;
        y_coord      <= p.y;
        last_pixel   <= p.last;
        do
        begin
            @(posedge clk);
        end
        while (in_ready !== 1'b1);
        sb.note_pixel(p);
        sent++;
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_W-1:0]     data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    task automatic apply_setting(input blob_setting_t s);
        put_reg(cbc_pkg::CFG_BALL_COLOR, CFG_W'(s.blue));
        put_reg(cbc_pkg::CFG_HUE_CENTER, CFG_W'(s.center));
        put_reg(cbc_pkg::CFG_HUE_BIAS, CFG_W'(s.half));
        put_reg(cbc_pkg::CFG_MIN_COUNT, s.min_hits);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic drain_results();
        int waited;
        waited   = 0;
        in_valid <= 1'b0;
        while (sb.awaited.size() > 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    initial
    begin : receiver
        int           gap;
        int           seen;
        blob_result_t got;
        seen      = 0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (seen == 150 || seen == 450)
                gap = LONG_HOLD;
            else if (seen % 64 < 16)
                gap = 0;
            else
                gap = $urandom_range(0, 8);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (out_valid !== 1'b1);
            got.mask  = mask_pixel;
            got.found = ball_found;
            got.count = match_count;
            got.xc    = x_center;
            got.yc    = y_center;
            sb.check_result(got);
            seen++;
        end
    end

    initial
    begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        blob_setting_t s;
        blob_setting_t corner_settings[4];
        int            phase_start;
        int            len;
        sb           = new();
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        pixel_rgb565 = '0;
        hue          = '0;
        saturation   = '0;
        brightness   = '0;
        x_coord      = '0;
        y_coord      = '0;
        last_pixel   = 1'b0;
        corner_settings = '{
            '{1'b0, 9'd0,   8'd179, 18'd0},
            '{1'b1, 9'd359, 8'd179, 18'h3FFFF},
            '{1'b1, 9'd359, 8'd0,   18'd0},
            '{1'b0, 9'd359, 8'd0,   18'd2}
        };
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: red target, zero-width window at 0, min 0
        send_pixel(mk_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pixel(mk_pixel(24, 25, 8, 10, 145, 103, 0, 0, 0));
        send_pixel(mk_pixel(27, 37, 14, 359, 255, 255, 511, 255, 0));
        send_pixel(mk_pixel(24, 25, 8, 0, 200, 200, 5, 5, 0));
        send_pixel(mk_pixel(24, 25, 8, 10, 144, 200, 5, 5, 0));
        send_pixel(mk_pixel(24, 25, 8, 10, 200, 102, 5, 5, 0));
        send_pixel(mk_pixel(23, 25, 8, 10, 200, 200, 5, 5, 0));
        send_pixel(mk_pixel(28, 25, 8, 10, 200, 200, 5, 5, 0));
        send_pixel(mk_pixel(24, 24, 8, 10, 200, 200, 5, 5, 0));
        send_pixel(mk_pixel(24, 25, 15, 10, 200, 200, 5, 5, 0));
        send_pixel(mk_pixel(31, 63, 31, 511, 255, 255, 511, 255, 1));
        send_pixel(mk_pixel(0, 0, 0, 0, 0, 0, 0, 0, 1));
        drain_results();

        s = '{1'b1, 9'd200, 8'd20, 18'd1};
        apply_setting(s);
        send_pixel(mk_pixel(7, 24, 16, 181, 145, 103, 100, 50, 0));
        send_pixel(mk_pixel(10, 32, 21, 219, 255, 255, 300, 200, 0));
        send_pixel(mk_pixel(8, 28, 18, 180, 200, 200, 10, 10, 0));
        send_pixel(mk_pixel(8, 28, 18, 220, 200, 200, 10, 10, 0));
        send_pixel(mk_pixel(8, 28, 18, 200, 200, 200, 20, 30, 1));
        send_pixel(mk_pixel(8, 28, 18, 200, 200, 200, 40, 60, 0));
        send_pixel(mk_pixel(11, 28, 18, 200, 200, 200, 40, 60, 1));
        drain_results();

        // window wraps below zero
        s = '{1'b0, 9'd10, 8'd30, 18'h3FFFF};
        apply_setting(s);
        send_pixel(mk_pixel(25, 30, 10, 100, 200, 200, 1, 2, 0));
        send_pixel(mk_pixel(25, 30, 10, 20, 200, 200, 3, 4, 0));
        send_pixel(mk_pixel(25, 30, 10, 350, 200, 200, 5, 6, 1));
        drain_results();

        // window wraps past 360
        s = '{1'b1, 9'd350, 8'd20, 18'd0};
        apply_setting(s);
        send_pixel(mk_pixel(9, 30, 19, 100, 200, 200, 77, 33, 0));
        send_pixel(mk_pixel(9, 30, 19, 340, 200, 200, 77, 33, 1));
        drain_results();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph < 4)
                s = corner_settings[ph];
            else
            begin
                s.blue   = 1'($urandom_range(0, 1));
                s.center = 9'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 511)
                                                           : $urandom_range(0, 359));
                s.half   = 8'(($urandom_range(0, 7) == 0) ? $urandom_range(180, 255)
                                                           : $urandom_range(0, 179));
                case ($urandom_range(0, 3))
                    0:       s.min_hits = '0;
                    3:       s.min_hits = CFG_W'($urandom_range(0, 18'h3FFFF));
                    default: s.min_hits = CFG_W'($urandom_range(1, 8));
                endcase
            end
            apply_setting(s);
            phase_start = sent;
            while (sent - phase_start < PHASE_ITEMS)
            begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
                for (int i = 0; i < len; i++)
                    send_pixel(rand_pixel(($urandom_range(0, 9) < 7) ? s.blue : !s.blue,
                                          i == len - 1, s));
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d pixels over %0d search windows under %0d register settings",
                 sent, sb.windows, settings_used);
        $display("%0d red and %0d blue matches, %0d windows found a blob, %0d mismatches",
                 sb.red_hits, sb.blue_hits, sb.blobs, sb.mismatches);
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("status: pass");
        else
        begin
            if (sb.awaited.size() != 0)
                $display("%0d results never arrived", sb.awaited.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule
